// File: src/dcn_pkg.sv
`default_nettype none

package dcn_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_W = 5;
  localparam logic [7:0] NODE_COUNT_RESET = 8'd120;
  localparam logic [7:0] STATUS_HI_MASK = 8'hF0;
  localparam logic [7:0] STATUS_LO_MASK = 8'h0F;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_GAP  = 2'd1,
    OP_TICK = 2'd2,
    OP_POP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [3:0] limit1_state;
    logic [3:0] limit2_state;
  } in_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               cmd1_valid;
    logic [7:0]         cmd1_byte;
    logic               cmd2_valid;
    logic [7:0]         cmd2_byte;
    logic [COUNT_W-1:0] queue1_count;
    logic [COUNT_W-1:0] queue2_count;
    logic               tx_overflow;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_next;
    logic               pop_ok;
  } q_stat_t;

  typedef struct packed {
    logic               pop_ok;
    logic [7:0]         pop_data;
    logic               overflow;
    logic [COUNT_W-1:0] count_next;
  } send_stat_t;

endpackage

`default_nettype wire

// File: src/dcn_cmd_queue.sv
`default_nettype none

module dcn_cmd_queue #(
  parameter int DEPTH = dcn_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dcn_pkg::q_ctl_t  ctl,
  input  wire logic [7:0]       wr_data,
  output dcn_pkg::q_stat_t      stat,
  output logic [7:0]            rd_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int OW = dcn_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] head_sum;
  logic [IW-1:0] tail;
  logic          push_ok;
  logic          pop_ok;

  assign push_ok = ctl.push && (count != FULL);
  assign pop_ok  = ctl.pop && (count != '0);

  always_comb begin
    tail_sum = SW'(head) + SW'(count);
    if (tail_sum >= DEPTH_S) begin
      tail_sum = tail_sum - DEPTH_S;
    end
    tail = tail_sum[IW-1:0];
    head_sum = SW'(head) + SW'(1);
    if (head_sum >= DEPTH_S) begin
      head_sum = '0;
    end
    head_next = pop_ok ? head_sum[IW-1:0] : head;
    count_next = count + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= wr_data;
    end
    if (pop_ok) begin
      rd_data <= mem[head];
    end
  end

  assign stat.count      = OW'(count);
  assign stat.count_next = OW'(count_next);
  assign stat.pop_ok     = pop_ok;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("command queue count beyond depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && !ctl.push && (count == '0)) |=> (count == '0))
    else $error("pop of an empty command queue changed the count");
`endif

endmodule

`default_nettype wire

// File: src/dcn_send_fifo.sv
`default_nettype none

module dcn_send_fifo #(
  parameter int DEPTH = dcn_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [2:0]       push_req,
  input  wire logic [2:0][7:0]  push_data,
  input  wire logic             pop_req,
  output dcn_pkg::send_stat_t   stat
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 2;
  localparam int OW = dcn_pkg::COUNT_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [2:0]    push_ok;
  logic [2:0][IW-1:0] widx;
  logic [SW-1:0] isum;
  logic [SW-1:0] head_sum;
  logic [CW-1:0] n_push;
  logic          pop_ok;

  always_comb begin
    n_push = '0;
    for (int k = 0; k < 3; k++) begin
      push_ok[k] = push_req[k] && ((SW'(count) + SW'(k)) < DEPTH_S);
      isum = SW'(head) + SW'(count) + SW'(k);
      if (isum >= DEPTH_S) begin
        isum = isum - DEPTH_S;
      end
      widx[k] = isum[IW-1:0];
      n_push = n_push + CW'(push_ok[k]);
    end
    pop_ok = pop_req && ((count != '0) || push_ok[0]);
    head_sum = SW'(head) + SW'(1);
    if (head_sum >= DEPTH_S) begin
      head_sum = '0;
    end
    count_next = count + n_push - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop_ok) begin
        head <= head_sum[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (push_ok[k]) begin
        mem[widx[k]] <= push_data[k];
      end
    end
  end

  assign stat.pop_ok     = pop_ok;
  assign stat.pop_data   = (count == '0) ? push_data[0] : mem[head];
  assign stat.overflow   = |(push_req & ~push_ok);
  assign stat.count_next = OW'(count_next);

endmodule

`default_nettype wire

// File: src/daisy_chain_serial_node_top.sv
`default_nettype none

// Node of a daisy-chained serial bus. Each transfer on the input channel is one
// event: a received byte, a gap timeout, a transmit slot tick or a pop of the
// two motor command queues, and each gives exactly one result transfer. Bytes
// at packet positions 0 and 1 fill the motor queues, the byte at the last
// position is forwarded with two status bytes, and other bytes pass through the
// transmit FIFO. The motor queues live in single-port synchronous RAMs read when
// a pop is accepted. A new event is taken every cycle while in_stall is low; a
// result passes through a holding stage and then an output register. An output
// register behind a holding stage lets one further event be taken while a result
// waits on out_stall. The user must write the node count register through cfg_we
// and cfg_data only while the node is idle; the block itself does not enforce it.
module daisy_chain_serial_node_top #(
  parameter int QUEUE_DEPTH = dcn_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire dcn_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dcn_pkg::out_t      out_data
);

  localparam int OW = dcn_pkg::COUNT_W;

  logic [7:0] node_count;
  logic [7:0] position;
  logic [7:0] position_next;
  logic       gap_running;
  logic       gap_running_next;
  logic       sender_running;
  logic       sender_running_next;

  logic       accept;
  logic       move;
  logic       is_rx;
  logic       is_gap;
  logic       is_tick;
  logic       is_pop;
  logic       last_pos;
  logic       fwd;
  logic       start;
  logic       tick;
  logic [7:0] status_byte;

  dcn_pkg::q_ctl_t     q1_ctl;
  dcn_pkg::q_ctl_t     q2_ctl;
  dcn_pkg::q_stat_t    q1_stat;
  dcn_pkg::q_stat_t    q2_stat;
  logic [7:0]          q1_rd;
  logic [7:0]          q2_rd;
  logic [2:0]          sq_push;
  logic [2:0][7:0]     sq_data;
  dcn_pkg::send_stat_t sq_stat;

  logic          s1_valid;
  logic          s1_tx_valid;
  logic [7:0]    s1_tx_byte;
  logic          s1_cmd1_valid;
  logic          s1_cmd2_valid;
  logic [OW-1:0] s1_q1_count;
  logic [OW-1:0] s1_q2_count;
  logic          s1_overflow;

  assign move     = !out_valid || !out_stall;
  assign in_stall = s1_valid && !move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_rx   = 1'b0;
    is_gap  = 1'b0;
    is_tick = 1'b0;
    is_pop  = 1'b0;
    case (in_data.op)
      dcn_pkg::OP_RX:   is_rx   = accept;
      dcn_pkg::OP_GAP:  is_gap  = accept;
      dcn_pkg::OP_TICK: is_tick = accept;
      dcn_pkg::OP_POP:  is_pop  = accept;
      default:          is_rx   = 1'b0;
    endcase
  end

  assign last_pos = (node_count != 8'd0) && (position == (node_count - 8'd1));
  assign fwd      = is_rx && (position != 8'd0) && (position != 8'd1);
  assign start    = fwd && !sender_running;
  assign tick     = start || (is_tick && sender_running);

  assign q1_ctl.push = is_rx && (position == 8'd0);
  assign q1_ctl.pop  = is_pop;
  assign q2_ctl.push = is_rx && (position == 8'd1);
  assign q2_ctl.pop  = is_pop;

  assign status_byte = ({q1_stat.count[3:0], 4'b0000} & dcn_pkg::STATUS_HI_MASK)
                     | ({4'b0000, q2_stat.count[3:0]} & dcn_pkg::STATUS_LO_MASK);

  assign sq_push    = {fwd && last_pos, fwd && last_pos, fwd};
  assign sq_data[0] = in_data.rx_byte;
  assign sq_data[1] = status_byte;
  assign sq_data[2] = {in_data.limit2_state, in_data.limit1_state};

  always_comb begin
    position_next    = position;
    gap_running_next = gap_running;
    if (is_rx) begin
      position_next    = position + 8'd1;
      gap_running_next = 1'b1;
    end else if (is_gap && gap_running) begin
      position_next    = 8'd0;
      gap_running_next = 1'b0;
    end
    sender_running_next = sender_running || start;
    if (tick && !gap_running_next && (sq_stat.count_next == '0)) begin
      sender_running_next = 1'b0;
    end
  end

  dcn_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue1 (
    .clk(clk),
    .rst(rst),
    .ctl(q1_ctl),
    .wr_data(in_data.rx_byte),
    .stat(q1_stat),
    .rd_data(q1_rd)
  );

  dcn_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue2 (
    .clk(clk),
    .rst(rst),
    .ctl(q2_ctl),
    .wr_data(in_data.rx_byte),
    .stat(q2_stat),
    .rd_data(q2_rd)
  );

  dcn_send_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_send (
    .clk(clk),
    .rst(rst),
    .push_req(sq_push),
    .push_data(sq_data),
    .pop_req(tick),
    .stat(sq_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= dcn_pkg::NODE_COUNT_RESET;
      position       <= 8'd0;
      gap_running    <= 1'b0;
      sender_running <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      position       <= position_next;
      gap_running    <= gap_running_next;
      sender_running <= sender_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tx_valid   <= sq_stat.pop_ok;
      s1_tx_byte    <= sq_stat.pop_ok ? sq_stat.pop_data : 8'd0;
      s1_cmd1_valid <= q1_stat.pop_ok;
      s1_cmd2_valid <= q2_stat.pop_ok;
      s1_q1_count   <= q1_stat.count_next;
      s1_q2_count   <= q2_stat.count_next;
      s1_overflow   <= sq_stat.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s1_valid) begin
      out_data.tx_valid     <= s1_tx_valid;
      out_data.tx_byte      <= s1_tx_byte;
      out_data.cmd1_valid   <= s1_cmd1_valid;
      out_data.cmd1_byte    <= s1_cmd1_valid ? q1_rd : 8'd0;
      out_data.cmd2_valid   <= s1_cmd2_valid;
      out_data.cmd2_byte    <= s1_cmd2_valid ? q2_rd : 8'd0;
      out_data.queue1_count <= s1_q1_count;
      out_data.queue2_count <= s1_q2_count;
      out_data.tx_overflow  <= s1_overflow;
    end
  end

`ifndef SYNTH
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transfer did not reach the holding stage");

  a_sender_stop: assert property (@(posedge clk) disable iff (rst)
    $fell(sender_running) |-> ($past(sq_stat.count_next) == '0))
    else $error("sender stopped with bytes left in the transmit FIFO");

  a_gap_reset: assert property (@(posedge clk) disable iff (rst)
    (is_gap && gap_running) |=> ((position == 8'd0) && !gap_running))
    else $error("gap timeout did not restart the packet position");
`endif

endmodule

`default_nettype wire

// File: tb/daisy_chain_serial_node_top_test.sv
`timescale 1ns / 100ps

module daisy_chain_serial_node_top_test;

  localparam int IDLE_LIMIT = 2000;
  localparam int CW = dcn_pkg::COUNT_W;

  class node_tracker;
    logic [7:0] node_count;
    logic [7:0] position;
    logic [7:0] motor1_q[$];
    logic [7:0] motor2_q[$];
    logic [7:0] send_q[$];
    bit sender_running;
    bit gap_running;
    dcn_pkg::out_t expected_results[$];
    int errors;
    int n_events;
    int n_sent;
    int n_dropped;
    int n_status;
    int n_cmds;

    function new();
      node_count = dcn_pkg::NODE_COUNT_RESET;
      position = '0;
      sender_running = 0;
      gap_running = 0;
      errors = 0;
      n_events = 0;
      n_sent = 0;
      n_dropped = 0;
      n_status = 0;
      n_cmds = 0;
    endfunction

    function bit push_send(logic [7:0] b);
      if (send_q.size() >= dcn_pkg::QUEUE_DEPTH) begin
        n_dropped++;
        return 0;
      end
      send_q.push_back(b);
      return 1;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_event(dcn_pkg::in_t it);
      dcn_pkg::out_t r;
      bit tick;
      logic [7:0] last_pos;
      int c1;
      int c2;
      r = '0;
      tick = 0;
      n_events++;
      case (it.op)
        dcn_pkg::OP_RX: begin
          gap_running = 1;
          if (position == 8'd0) begin
            if (motor1_q.size() < dcn_pkg::QUEUE_DEPTH) motor1_q.push_back(it.rx_byte);
          end else if (position == 8'd1) begin
            if (motor2_q.size() < dcn_pkg::QUEUE_DEPTH) motor2_q.push_back(it.rx_byte);
          end else begin
            if (!sender_running) begin
              sender_running = 1;
              tick = 1;
            end
            if (!push_send(it.rx_byte)) r.tx_overflow = 1'b1;
            last_pos = node_count - 8'd1;
            if (node_count != 8'd0 && position == last_pos) begin
              c1 = motor1_q.size();
              c2 = motor2_q.size();
              n_status++;
              if (!push_send({c1[3:0], c2[3:0]})) r.tx_overflow = 1'b1;
              if (!push_send({it.limit2_state, it.limit1_state})) r.tx_overflow = 1'b1;
            end
          end
          position = position + 8'd1;
        end
        dcn_pkg::OP_GAP: begin
          if (gap_running) begin
            position = '0;
            gap_running = 0;
          end
        end
        dcn_pkg::OP_TICK: begin
          if (sender_running) tick = 1;
        end
        dcn_pkg::OP_POP: begin
          if (motor1_q.size() > 0) begin
            r.cmd1_valid = 1'b1;
            r.cmd1_byte = motor1_q.pop_front();
            n_cmds++;
          end
          if (motor2_q.size() > 0) begin
            r.cmd2_valid = 1'b1;
            r.cmd2_byte = motor2_q.pop_front();
            n_cmds++;
          end
        end
        default: begin
        end
      endcase
      if (tick) begin
        if (send_q.size() > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = send_q.pop_front();
          n_sent++;
        end
        if (!gap_running && send_q.size() == 0) sender_running = 0;
      end
      r.queue1_count = CW'(motor1_q.size());
      r.queue2_count = CW'(motor2_q.size());
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(dcn_pkg::out_t got);
      dcn_pkg::out_t exp_r;
      if (expected_results.size() == 0) begin
        $error("Result transfer with no expectation waiting: %h", got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("tx_valid", exp_r.tx_valid, got.tx_valid);
      compare_field("tx_byte", exp_r.tx_byte, got.tx_byte);
      compare_field("cmd1_valid", exp_r.cmd1_valid, got.cmd1_valid);
      compare_field("cmd1_byte", exp_r.cmd1_byte, got.cmd1_byte);
      compare_field("cmd2_valid", exp_r.cmd2_valid, got.cmd2_valid);
      compare_field("cmd2_byte", exp_r.cmd2_byte, got.cmd2_byte);
      compare_field("queue1_count", exp_r.queue1_count, got.queue1_count);
      compare_field("queue2_count", exp_r.queue2_count, got.queue2_count);
      compare_field("tx_overflow", exp_r.tx_overflow, got.tx_overflow);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_stall;
  dcn_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  dcn_pkg::out_t out_data;

  node_tracker sb = new();

  int burst_left = 1;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  daisy_chain_serial_node_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic dcn_pkg::in_t make_item(dcn_pkg::op_t op, logic [7:0] rx,
                                             logic [3:0] l1, logic [3:0] l2);
    dcn_pkg::in_t it;
    it.op = op;
    it.rx_byte = rx;
    it.limit1_state = l1;
    it.limit2_state = l2;
    return it;
  endfunction

  task automatic send_item(dcn_pkg::in_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(it);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 60);
      end else begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_op(dcn_pkg::op_t op);
    send_item(make_item(op, 8'($urandom), 4'($urandom), 4'($urandom)));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.node_count = value;
  endtask

  task automatic run_packet(int len, int tick_pct, int pop_pct);
    send_op(dcn_pkg::OP_GAP);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_op(dcn_pkg::OP_TICK);
      if ($urandom_range(0, 99) < pop_pct) send_op(dcn_pkg::OP_POP);
      send_op(dcn_pkg::OP_RX);
    end
  endtask

  task automatic run_phase(logic [7:0] count, int target);
    int start;
    int len;
    int tick_pct;
    int pop_pct;
    start = sb.n_events;
    while (sb.n_events - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        send_op(dcn_pkg::op_t'($urandom_range(0, 3)));
      end else begin
        if (count == 8'd0) len = $urandom_range(2, 8);
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, count);
        else len = count + $urandom_range(0, 2) - 1;
        if (len < 1) len = 1;
        case ($urandom_range(0, 3))
          0: tick_pct = 0;
          1: tick_pct = 20;
          2: tick_pct = 50;
          default: tick_pct = 90;
        endcase
        case ($urandom_range(0, 4))
          0, 1, 2: pop_pct = 0;
          3: pop_pct = 10;
          default: pop_pct = 40;
        endcase
        run_packet(len, tick_pct, pop_pct);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_node_count(dcn_pkg::NODE_COUNT_RESET);
    send_item(make_item(dcn_pkg::OP_TICK, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_GAP, 8'hFF, 4'hF, 4'hF));
    send_item(make_item(dcn_pkg::OP_POP, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_RX, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_RX, 8'hFF, 4'hF, 4'hF));
    send_item(make_item(dcn_pkg::OP_RX, 8'hA5, 4'h0, 4'hF));
    send_item(make_item(dcn_pkg::OP_RX, 8'h5A, 4'hF, 4'h0));
    send_item(make_item(dcn_pkg::OP_TICK, 8'hFF, 4'hF, 4'hF));
    send_item(make_item(dcn_pkg::OP_TICK, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_POP, 8'hFF, 4'hF, 4'hF));
    send_item(make_item(dcn_pkg::OP_POP, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_GAP, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_TICK, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_TICK, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_GAP, 8'h00, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_RX, 8'h80, 4'h5, 4'hA));
    send_item(make_item(dcn_pkg::OP_RX, 8'h01, 4'hA, 4'h5));
    send_item(make_item(dcn_pkg::OP_RX, 8'h7F, 4'h0, 4'h0));
    send_item(make_item(dcn_pkg::OP_GAP, 8'h00, 4'h0, 4'h0));
    wait_for_results();

    write_node_count(8'd1);
    run_phase(8'd1, 35);
    wait_for_results();
    write_node_count(8'd2);
    run_phase(8'd2, 30);
    wait_for_results();
    write_node_count(8'd0);
    run_phase(8'd0, 25);
    wait_for_results();
    write_node_count(8'd3);
    run_phase(8'd3, 30);
    wait_for_results();
    write_node_count(8'd6);
    run_phase(8'd6, 30);
    wait_for_results();

    // One run past 256 bytes reaches the last position and wraps into the command slots.
    write_node_count(8'd255);
    run_packet(258, 5, 3);

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d events over node counts 120, 1, 2, 0, 3, 6 and 255.", sb.n_events);
    $display("Bytes sent %0d, dropped %0d, status pairs %0d, commands popped %0d.",
             sb.n_sent, sb.n_dropped, sb.n_status, sb.n_cmds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
